// File: sv/fleq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fleq_pkg;

  // Widths of the word fields.
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned REF_W   = 32;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LAG_W   = 32;

  // Input word modes.
  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_INIT    = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef enum logic [3:0] {
    ST_ACCEPTED    = 4'd0,
    ST_RELEASED    = 4'd1,
    ST_TICK_DONE   = 4'd2,
    ST_NOT_READY   = 4'd3,
    ST_INVALID     = 4'd4,
    ST_STALE       = 4'd5,
    ST_OVERFLOW    = 4'd6,
    ST_BACKWARDS   = 4'd7,
    ST_FAILED      = 4'd8,
    ST_INITIALIZED = 4'd9
  } status_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_REPORT,
    OP_INIT,
    OP_STALE,
    OP_OVERFLOW,
    OP_INSERT,
    OP_TICK_START,
    OP_RELEASE,
    OP_GAP_FAIL,
    OP_TICK_DONE
  } op_t;

  typedef struct packed {
    logic    capture;
    op_t     op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       ready;
    logic       failed;
    logic       kind_bad;
    logic       stale;
    logic       full;
    logic       backwards;
    logic       head_due;
    logic       head_gap_bad;
    logic       final_gap_bad;
  } dp_flags_t;

endpackage

`default_nettype wire

// File: sv/fleq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fleq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire fleq_pkg::dp_flags_t flags,
  output fleq_pkg::dp_cmd_t        cmd
);
  import fleq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TICK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  assign busy = busy_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    cmd.code    = ST_ACCEPTED;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (flags.mode == MODE_INIT) begin
          cmd.op   = OP_INIT;
          cmd.code = ST_INITIALIZED;
        end else if (flags.mode == MODE_UNUSED) begin
          cmd.op   = OP_REPORT;
          cmd.code = ST_INVALID;
        end else if (!flags.ready) begin
          cmd.op   = OP_REPORT;
          cmd.code = ST_NOT_READY;
        end else if (flags.failed) begin
          cmd.op   = OP_REPORT;
          cmd.code = ST_FAILED;
        end else if (flags.mode == MODE_ENQUEUE) begin
          if (flags.kind_bad) begin
            cmd.op   = OP_REPORT;
            cmd.code = ST_INVALID;
          end else if (flags.stale) begin
            cmd.op   = OP_STALE;
            cmd.code = ST_STALE;
          end else if (flags.full) begin
            cmd.op   = OP_OVERFLOW;
            cmd.code = ST_OVERFLOW;
          end else begin
            cmd.op   = OP_INSERT;
            cmd.code = ST_ACCEPTED;
          end
        end else if (flags.backwards) begin
          cmd.op   = OP_REPORT;
          cmd.code = ST_BACKWARDS;
        end else begin
          cmd.op    = OP_TICK_START;
          state_nxt = S_TICK;
        end
      end
      S_TICK: begin
        if (flags.head_due) begin
          if (flags.head_gap_bad) begin
            cmd.op    = OP_GAP_FAIL;
            cmd.code  = ST_FAILED;
            state_nxt = S_IDLE;
          end else begin
            cmd.op   = OP_RELEASE;
            cmd.code = ST_RELEASED;
          end
        end else if (flags.final_gap_bad) begin
          cmd.op    = OP_GAP_FAIL;
          cmd.code  = ST_FAILED;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_TICK_DONE;
          cmd.code  = ST_TICK_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/fleq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fleq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned KIND_COUNT  = 5,
  parameter int unsigned MAX_GAP_US  = 200000
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fleq_pkg::dp_cmd_t                cmd,
  output fleq_pkg::dp_flags_t                   flags,
  input  wire logic                             cfg_we,
  input  wire logic [fleq_pkg::LAG_W-1:0]       cfg_wdata,
  input  wire logic [1:0]                       in_mode,
  input  wire logic [fleq_pkg::TIME_W-1:0]      in_timestamp,
  input  wire logic [fleq_pkg::KIND_W-1:0]      in_event_kind,
  input  wire logic [fleq_pkg::REF_W-1:0]       in_payload_ref,
  input  wire logic                             in_data_finite,
  output logic                                  out_strobe,
  output logic [3:0]                            out_status,
  output logic [fleq_pkg::KIND_W-1:0]           out_kind,
  output logic [fleq_pkg::TIME_W-1:0]           out_time,
  output logic [fleq_pkg::REF_W-1:0]            out_payload,
  output logic [fleq_pkg::LEVEL_W-1:0]          out_queue_level,
  output logic [fleq_pkg::CNT_W-1:0]            out_stale_total,
  output logic [fleq_pkg::CNT_W-1:0]            out_overflow_total,
  output logic [fleq_pkg::TIME_W-1:0]           out_fusion_now,
  output logic                                  out_last
);
  import fleq_pkg::*;

  // Captured input word.
  logic [1:0]        mode_r;
  logic [TIME_W-1:0] ts_r;
  logic [KIND_W-1:0] kind_r;
  logic [REF_W-1:0]  ref_r;
  logic              finite_r;

  // Sorted event cells; cell 0 is the oldest.
  logic [TIME_W-1:0] slot_time_r    [QUEUE_DEPTH];
  logic [KIND_W-1:0] slot_kind_r    [QUEUE_DEPTH];
  logic [REF_W-1:0]  slot_payload_r [QUEUE_DEPTH];

  logic [LEVEL_W-1:0] held_r;
  logic [TIME_W-1:0]  newest_r [KIND_COUNT];
  logic [TIME_W-1:0]  fusion_r;
  logic [TIME_W-1:0]  prev_tick_r;
  logic [TIME_W-1:0]  start_r;
  logic [TIME_W-1:0]  horizon_r;
  logic [LAG_W-1:0]   lag_r;
  logic               ready_r;
  logic               failed_r;
  logic [CNT_W-1:0]   stale_cnt_r;
  logic [CNT_W-1:0]   ovf_cnt_r;

  logic               strobe_r;
  status_t            status_r;
  logic [KIND_W-1:0]  okind_r;
  logic [TIME_W-1:0]  otime_r;
  logic [REF_W-1:0]   opay_r;
  logic               last_r;

  logic [QUEUE_DEPTH-1:0] place;
  logic [TIME_W-1:0]      newest_sel;
  logic [TIME_W-1:0]      horizon_calc;
  logic [TIME_W:0]        head_diff;
  logic [TIME_W:0]        final_diff;
  logic                   emit;
  logic                   do_insert;
  logic                   do_pop;

  localparam logic [TIME_W-1:0] MaxGap = TIME_W'(MAX_GAP_US);

  // A cell is at or past the insert point when it is empty or sorts after the new event.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      place[i] = (LEVEL_W'(i) >= held_r) || (slot_time_r[i] > ts_r) ||
                 ((slot_time_r[i] == ts_r) && (slot_kind_r[i] > kind_r));
    end
  end

  always_comb begin
    newest_sel = '0;
    for (int k = 0; k < KIND_COUNT; k++) begin
      if (kind_r == KIND_W'(k)) newest_sel = newest_r[k];
    end
  end

  assign horizon_calc = (ts_r >= TIME_W'(lag_r)) ? (ts_r - TIME_W'(lag_r)) : '0;
  assign head_diff    = {1'b0, slot_time_r[0]} - {1'b0, fusion_r};
  assign final_diff   = {1'b0, horizon_r} - {1'b0, fusion_r};

  always_comb begin
    flags.mode          = mode_r;
    flags.ready         = ready_r;
    flags.failed        = failed_r;
    flags.kind_bad      = ({1'b0, kind_r} >= (KIND_W + 1)'(KIND_COUNT)) || !finite_r;
    flags.stale         = (ts_r <= newest_sel) || (ts_r < fusion_r);
    flags.full          = (held_r >= LEVEL_W'(QUEUE_DEPTH));
    flags.backwards     = (ts_r < prev_tick_r) || (ts_r < start_r);
    flags.head_due      = (held_r != '0) && (slot_time_r[0] <= horizon_r);
    flags.head_gap_bad  = head_diff[TIME_W] || (head_diff[TIME_W-1:0] > MaxGap);
    flags.final_gap_bad = !final_diff[TIME_W] && (final_diff[TIME_W-1:0] > MaxGap);
  end

  assign emit      = (cmd.op != OP_NONE) && (cmd.op != OP_TICK_START);
  assign do_insert = (cmd.op == OP_INSERT);
  assign do_pop    = (cmd.op == OP_RELEASE);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      ts_r     <= in_timestamp;
      kind_r   <= in_event_kind;
      ref_r    <= in_payload_ref;
      finite_r <= in_data_finite;
    end
    if (cmd.op == OP_TICK_START) begin
      horizon_r <= horizon_calc;
    end
  end

  // Each cell either holds, takes the new event, takes its older neighbor on an
  // insert, or takes its younger neighbor on a release.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (g == 0) begin
          if (place[g]) begin
            slot_time_r[g]    <= ts_r;
            slot_kind_r[g]    <= kind_r;
            slot_payload_r[g] <= ref_r;
          end
        end else if (place[g] && !place[(g == 0) ? 0 : g - 1]) begin
          slot_time_r[g]    <= ts_r;
          slot_kind_r[g]    <= kind_r;
          slot_payload_r[g] <= ref_r;
        end else if (place[g]) begin
          slot_time_r[g]    <= slot_time_r[(g == 0) ? 0 : g - 1];
          slot_kind_r[g]    <= slot_kind_r[(g == 0) ? 0 : g - 1];
          slot_payload_r[g] <= slot_payload_r[(g == 0) ? 0 : g - 1];
        end
      end else if (do_pop && (g + 1 < QUEUE_DEPTH)) begin
        slot_time_r[g]    <= slot_time_r[(g + 1 < QUEUE_DEPTH) ? g + 1 : g];
        slot_kind_r[g]    <= slot_kind_r[(g + 1 < QUEUE_DEPTH) ? g + 1 : g];
        slot_payload_r[g] <= slot_payload_r[(g + 1 < QUEUE_DEPTH) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      fusion_r    <= '0;
      prev_tick_r <= '0;
      start_r     <= '0;
      lag_r       <= '0;
      ready_r     <= 1'b0;
      failed_r    <= 1'b0;
      stale_cnt_r <= '0;
      ovf_cnt_r   <= '0;
      strobe_r    <= 1'b0;
      for (int k = 0; k < KIND_COUNT; k++) newest_r[k] <= '0;
    end else begin
      if (cfg_we) lag_r <= cfg_wdata;
      strobe_r <= emit;
      case (cmd.op)
        OP_INIT: begin
          held_r      <= '0;
          fusion_r    <= ts_r;
          start_r     <= ts_r;
          prev_tick_r <= '0;
          ready_r     <= 1'b1;
          failed_r    <= 1'b0;
          stale_cnt_r <= '0;
          ovf_cnt_r   <= '0;
          for (int k = 0; k < KIND_COUNT; k++) newest_r[k] <= ts_r;
        end
        OP_STALE: stale_cnt_r <= stale_cnt_r + 1'b1;
        OP_OVERFLOW: begin
          ovf_cnt_r <= ovf_cnt_r + 1'b1;
          failed_r  <= 1'b1;
        end
        OP_INSERT: begin
          held_r <= held_r + 1'b1;
          for (int k = 0; k < KIND_COUNT; k++) begin
            if (kind_r == KIND_W'(k)) newest_r[k] <= ts_r;
          end
        end
        OP_TICK_START: prev_tick_r <= ts_r;
        OP_RELEASE: begin
          held_r   <= held_r - 1'b1;
          fusion_r <= slot_time_r[0];
        end
        OP_GAP_FAIL: failed_r <= 1'b1;
        OP_TICK_DONE: begin
          if (!final_diff[TIME_W]) fusion_r <= horizon_r;
        end
        default: ;
      endcase
    end
  end

  // Result word fields; the level, counters and fusion time come straight from state,
  // which already holds the values after the result during its strobe cycle.
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= cmd.code;
      last_r   <= !do_pop;
      if (do_pop) begin
        okind_r <= slot_kind_r[0];
        otime_r <= slot_time_r[0];
        opay_r  <= slot_payload_r[0];
      end else begin
        okind_r <= '0;
        otime_r <= '0;
        opay_r  <= '0;
      end
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_kind           = okind_r;
  assign out_time           = otime_r;
  assign out_payload        = opay_r;
  assign out_last           = last_r;
  assign out_queue_level    = held_r;
  assign out_stale_total    = stale_cnt_r;
  assign out_overflow_total = ovf_cnt_r;
  assign out_fusion_now     = fusion_r;

endmodule

`default_nettype wire

// File: sv/fixed_lag_event_reorder_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-lag reorder queue for timestamped sensor events.
// Input channel: a word (in_mode, in_timestamp, in_event_kind, in_payload_ref,
// in_data_finite) is taken at a rising edge with start high and busy low.
// Result channel: each result word is on the out_ ports for exactly one cycle,
// marked by out_strobe; out_last flags the final word of an input.
// Configuration: cfg_we with cfg_wdata writes the lag register;
// write it only while the block is idle.
// Results: an enqueue, initialize or rejected word gives its single result word,
// and the block takes no new word while it is busy. A tick releases its due
// events in time order: the release loop pops one event per cycle from the head
// of the sorted cell row, and the final tick-done or failure word follows in the
// next cycle.
// Insertion is a parallel compare-and-shift over the cell row.
// Reset clears the controller, the queue level, the flags, the counters, the
// fusion and tick times and the lag register. The receiver cannot stall, so
// there is no back-pressure on the result channel.
module fixed_lag_event_reorder_queue #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned KIND_COUNT  = 5,
  parameter int unsigned MAX_GAP_US  = 200000
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [fleq_pkg::TIME_W-1:0] in_timestamp,
  input  wire logic [fleq_pkg::KIND_W-1:0] in_event_kind,
  input  wire logic [fleq_pkg::REF_W-1:0]  in_payload_ref,
  input  wire logic                        in_data_finite,
  input  wire logic                        cfg_we,
  input  wire logic [fleq_pkg::LAG_W-1:0]  cfg_wdata,
  output logic                             out_strobe,
  output logic [3:0]                       out_status,
  output logic [fleq_pkg::KIND_W-1:0]      out_kind,
  output logic [fleq_pkg::TIME_W-1:0]      out_time,
  output logic [fleq_pkg::REF_W-1:0]       out_payload,
  output logic [fleq_pkg::LEVEL_W-1:0]     out_queue_level,
  output logic [fleq_pkg::CNT_W-1:0]       out_stale_total,
  output logic [fleq_pkg::CNT_W-1:0]       out_overflow_total,
  output logic [fleq_pkg::TIME_W-1:0]      out_fusion_now,
  output logic                             out_last
);
  import fleq_pkg::*;

  // The controller only sequences; every decision it makes past accepting start
  // is taken from flags that the datapath derives from its registered state.
  dp_cmd_t   cmd;
  dp_flags_t flags;

  fleq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  fleq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KIND_COUNT  (KIND_COUNT),
    .MAX_GAP_US  (MAX_GAP_US)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .flags              (flags),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_mode),
    .in_timestamp       (in_timestamp),
    .in_event_kind      (in_event_kind),
    .in_payload_ref     (in_payload_ref),
    .in_data_finite     (in_data_finite),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_kind           (out_kind),
    .out_time           (out_time),
    .out_payload        (out_payload),
    .out_queue_level    (out_queue_level),
    .out_stale_total    (out_stale_total),
    .out_overflow_total (out_overflow_total),
    .out_fusion_now     (out_fusion_now),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// File: sv/fleq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fleq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_strobe,
  input wire logic [3:0]                  out_status,
  input wire logic [fleq_pkg::KIND_W-1:0] out_kind,
  input wire logic [fleq_pkg::TIME_W-1:0] out_time,
  input wire logic [fleq_pkg::REF_W-1:0]  out_payload,
  input wire logic                        out_last
);
  import fleq_pkg::*;

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // A release word is always followed by another word of the same tick.
  a_release_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("release word not followed by a result word");

  // The final word of an input is shown while the block is already idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("block still busy on the final word");

  // Only release words carry event fields, and they are never final.
  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_RELEASED) |->
      (out_kind == '0) && (out_time == '0) && (out_payload == '0))
    else $error("event fields set on a word that is not a release");

  a_release_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_RELEASED) |-> !out_last)
    else $error("release word marked as final");

endmodule

bind fixed_lag_event_reorder_queue fleq_checker u_fleq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_strobe  (out_strobe),
  .out_status  (out_status),
  .out_kind    (out_kind),
  .out_time    (out_time),
  .out_payload (out_payload),
  .out_last    (out_last)
);

`default_nettype wire
